### src/sipl_pkg.sv
// ============================================================================
// sipl_pkg: shared constants for the sorted interval pointer lookup
// Field widths, opcode and status codes, and default table geometry.
// ============================================================================
package sipl_pkg;

   // default geometry
   localparam int DEF_TABLE_DEPTH  = 1024;
   localparam int DEF_ADDRESS_BITS = 48;

   // fixed field widths
   localparam int OPCODE_BITS = 2;
   localparam int SIZE_BITS   = 32;
   localparam int STATUS_BITS = 3;

   // request opcodes
   localparam logic [OPCODE_BITS-1:0] OP_CLEAR  = 2'd0;
   localparam logic [OPCODE_BITS-1:0] OP_APPEND = 2'd1;
   localparam logic [OPCODE_BITS-1:0] OP_LOOKUP = 2'd2;

   // response status codes
   localparam logic [STATUS_BITS-1:0] ST_DONE  = 3'd0;
   localparam logic [STATUS_BITS-1:0] ST_HIT   = 3'd1;
   localparam logic [STATUS_BITS-1:0] ST_MISS  = 3'd2;
   localparam logic [STATUS_BITS-1:0] ST_FULL  = 3'd3;
   localparam logic [STATUS_BITS-1:0] ST_ORDER = 3'd4;

endpackage

### src/sipl_ifs.sv
// ============================================================================
// sipl request and response channels
// Valid/ready channels; a transfer happens when valid and ready are both high.
// ============================================================================

// request channel: opcode, address, object size
interface sipl_req_if #(
   parameter int ADDRESS_BITS = sipl_pkg::DEF_ADDRESS_BITS
);
   logic                             valid;
   logic                             ready;
   logic [sipl_pkg::OPCODE_BITS-1:0] opcode;
   logic [ADDRESS_BITS-1:0]          address;
   logic [sipl_pkg::SIZE_BITS-1:0]   object_bytes;

   modport source (output valid, opcode, address, object_bytes, input ready);
   modport sink   (input valid, opcode, address, object_bytes, output ready);
endinterface

// response channel: status, matched base and index
interface sipl_rsp_if #(
   parameter int ADDRESS_BITS = sipl_pkg::DEF_ADDRESS_BITS,
   parameter int INDEX_BITS   = $clog2(sipl_pkg::DEF_TABLE_DEPTH)
);
   logic                             valid;
   logic                             ready;
   logic [sipl_pkg::STATUS_BITS-1:0] status;
   logic [ADDRESS_BITS-1:0]          hit_base;
   logic [INDEX_BITS-1:0]            hit_index;

   modport source (output valid, status, hit_base, hit_index, input ready);
   modport sink   (input valid, status, hit_base, hit_index, output ready);
endinterface

### src/sorted_interval_pointer_lookup.sv
// ============================================================================
// sorted_interval_pointer_lookup: pointer filter over a sorted object table
// Appends object base/size pairs in ascending base order and answers whether
// an address falls inside one of the objects, returning its base and index.
//
//   channel | dir | transfer carries
//   --------+-----+-------------------------------------------
//   req_bus | in  | opcode, address, object_bytes
//   rsp_bus | out | status, hit_base, hit_index (one per request)
//
// Lookup: the request passes through the chain of cells, the first of which
//   loads at the transfer edge, then the bounds check register, the pending
//   result register and the response register, which drives response valid.
// Clear, append and the unused opcode: the pending result register, then the response register.
// One request is in flight at a time; the next is taken once the previous
//   result has moved into the response register, even if that is stalled.
// Reset empties the table; entry storage is not cleared.
// ============================================================================
module sorted_interval_pointer_lookup #(
   parameter int TABLE_DEPTH  = sipl_pkg::DEF_TABLE_DEPTH,
   parameter int ADDRESS_BITS = sipl_pkg::DEF_ADDRESS_BITS
) (
   input  logic        clock,
   input  logic        reset,
   sipl_req_if.sink    req_bus,
   sipl_rsp_if.source  rsp_bus
);

   localparam int CNT_BITS    = $clog2(TABLE_DEPTH + 1);
   localparam int INDEX_BITS  = $clog2(TABLE_DEPTH);
   localparam int SIZE_BITS   = sipl_pkg::SIZE_BITS;
   localparam int STATUS_BITS = sipl_pkg::STATUS_BITS;

   // control state
   logic                    busy_ff, busy_in;
   logic [CNT_BITS-1:0]     count_ff, count_in;
   logic [ADDRESS_BITS-1:0] last_base_ff, last_base_in;
   logic                    pend_valid_ff, pend_valid_in;
   logic                    rsp_valid_ff, rsp_valid_in;

   // result payload
   logic [STATUS_BITS-1:0]  pend_status_ff, pend_status_in;
   logic [ADDRESS_BITS-1:0] pend_base_ff, pend_base_in;
   logic [INDEX_BITS-1:0]   pend_index_ff, pend_index_in;
   logic [STATUS_BITS-1:0]  rsp_status_ff, rsp_status_in;
   logic [ADDRESS_BITS-1:0] rsp_base_ff, rsp_base_in;
   logic [INDEX_BITS-1:0]   rsp_index_ff, rsp_index_in;

   logic                    accept;
   logic                    imm_valid;
   logic [STATUS_BITS-1:0]  imm_status;
   logic                    wr_en;
   logic                    search_start;
   logic                    move;

   // search chain links; link 0 is the request, link CNT_BITS the last cell
   logic [CNT_BITS:0]       link_valid;
   logic [CNT_BITS-1:0]     link_pos  [CNT_BITS+1];
   logic [ADDRESS_BITS-1:0] link_addr [CNT_BITS+1];
   logic [ADDRESS_BITS-1:0] link_base [CNT_BITS+1];
   logic [SIZE_BITS-1:0]    link_size [CNT_BITS+1];

   logic                    chk_valid;
   logic [STATUS_BITS-1:0]  chk_status;
   logic [ADDRESS_BITS-1:0] chk_base;
   logic [INDEX_BITS-1:0]   chk_index;

   assign req_bus.ready = !busy_ff;
   assign accept        = req_bus.valid && req_bus.ready;

   // clear, append and unused opcodes finish at once; lookup enters the chain
   always_comb begin
      count_in     = count_ff;
      last_base_in = last_base_ff;
      imm_status   = sipl_pkg::ST_DONE;
      wr_en        = 1'b0;
      imm_valid    = 1'b0;
      search_start = 1'b0;
      if (accept) begin
         unique case (req_bus.opcode)
            sipl_pkg::OP_CLEAR: begin
               imm_valid = 1'b1;
               count_in  = '0;
            end
            sipl_pkg::OP_APPEND: begin
               imm_valid = 1'b1;
               if (count_ff >= CNT_BITS'(TABLE_DEPTH)) begin
                  imm_status = sipl_pkg::ST_FULL;
               end else if (count_ff != '0 && req_bus.address <= last_base_ff) begin
                  imm_status = sipl_pkg::ST_ORDER;
               end else begin
                  wr_en        = 1'b1;
                  count_in     = count_ff + CNT_BITS'(1);
                  last_base_in = req_bus.address;
               end
            end
            sipl_pkg::OP_LOOKUP: begin
               search_start = 1'b1;
            end
            default: begin
               imm_valid = 1'b1;
            end
         endcase
      end
   end

   assign link_valid[0] = search_start;
   assign link_pos[0]   = '0;
   assign link_addr[0]  = req_bus.address;
   assign link_base[0]  = '0;
   assign link_size[0]  = '0;

   // chain of cells, largest step first
   for (genvar g = 0; g < CNT_BITS; g++) begin : g_cell
      sipl_cell #(
         .LEVEL        (CNT_BITS - 1 - g),
         .TABLE_DEPTH  (TABLE_DEPTH),
         .ADDRESS_BITS (ADDRESS_BITS)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .wr_en     (wr_en),
         .wr_index  (count_ff),
         .wr_base   (req_bus.address),
         .wr_size   (req_bus.object_bytes),
         .count     (count_ff),
         .in_valid  (link_valid[g]),
         .in_pos    (link_pos[g]),
         .in_addr   (link_addr[g]),
         .in_base   (link_base[g]),
         .in_size   (link_size[g]),
         .out_valid (link_valid[g+1]),
         .out_pos   (link_pos[g+1]),
         .out_addr  (link_addr[g+1]),
         .out_base  (link_base[g+1]),
         .out_size  (link_size[g+1])
      );
   end

   sipl_check #(
      .TABLE_DEPTH  (TABLE_DEPTH),
      .ADDRESS_BITS (ADDRESS_BITS)
   ) u_check (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (link_valid[CNT_BITS]),
      .in_pos     (link_pos[CNT_BITS]),
      .in_addr    (link_addr[CNT_BITS]),
      .in_base    (link_base[CNT_BITS]),
      .in_size    (link_size[CNT_BITS]),
      .out_valid  (chk_valid),
      .out_status (chk_status),
      .out_base   (chk_base),
      .out_index  (chk_index)
   );

   // pending result and response register
   always_comb begin
      move          = pend_valid_ff && (!rsp_valid_ff || rsp_bus.ready);
      busy_in       = busy_ff;
      pend_valid_in = pend_valid_ff;
      rsp_valid_in  = rsp_valid_ff;
      if (accept) begin
         busy_in = 1'b1;
      end else if (move) begin
         busy_in = 1'b0;
      end
      if (imm_valid || chk_valid) begin
         pend_valid_in = 1'b1;
      end else if (move) begin
         pend_valid_in = 1'b0;
      end
      if (move) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end

      pend_status_in = pend_status_ff;
      pend_base_in   = pend_base_ff;
      pend_index_in  = pend_index_ff;
      if (chk_valid) begin
         pend_status_in = chk_status;
         pend_base_in   = chk_base;
         pend_index_in  = chk_index;
      end else if (imm_valid) begin
         pend_status_in = imm_status;
         pend_base_in   = '0;
         pend_index_in  = '0;
      end

      rsp_status_in = move ? pend_status_ff : rsp_status_ff;
      rsp_base_in   = move ? pend_base_ff   : rsp_base_ff;
      rsp_index_in  = move ? pend_index_ff  : rsp_index_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff       <= 1'b0;
         count_ff      <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         busy_ff       <= busy_in;
         count_ff      <= count_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      last_base_ff   <= last_base_in;
      pend_status_ff <= pend_status_in;
      pend_base_ff   <= pend_base_in;
      pend_index_ff  <= pend_index_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_base_ff    <= rsp_base_in;
      rsp_index_ff   <= rsp_index_in;
   end

   assign rsp_bus.valid     = rsp_valid_ff;
   assign rsp_bus.status    = rsp_status_ff;
   assign rsp_bus.hit_base  = rsp_base_ff;
   assign rsp_bus.hit_index = rsp_index_ff;

   // at most one request anywhere between chain entry and response handoff
   a_single_token: assert property (@(posedge clock) disable iff (reset)
      $onehot0({link_valid[CNT_BITS:1], chk_valid, pend_valid_ff}))
      else $error("more than one request in flight");

   // the entry count never passes the table depth
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_BITS'(TABLE_DEPTH))
      else $error("entry count beyond table depth");

   // a pending result always belongs to a request still marked busy
   a_pend_busy: assert property (@(posedge clock) disable iff (reset)
      pend_valid_ff |-> busy_ff)
      else $error("pending result without busy request");

endmodule

### src/sipl_cell.sv
// ============================================================================
// sipl_cell: one step of the search chain
// Holds the table entries whose index ends in exactly LEVEL one bits, which
// are the only entries the search step of size 2**LEVEL ever probes. Each
// cycle it takes the running position from its neighbor, reads its row,
// and hands the advanced position and floor candidate to the next cell.
// ============================================================================
module sipl_cell #(
   parameter int LEVEL        = 0,
   parameter int TABLE_DEPTH  = sipl_pkg::DEF_TABLE_DEPTH,
   parameter int ADDRESS_BITS = sipl_pkg::DEF_ADDRESS_BITS
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // append port, broadcast to every cell
   input  logic                                 wr_en,
   input  logic [$clog2(TABLE_DEPTH+1)-1:0]     wr_index,
   input  logic [ADDRESS_BITS-1:0]              wr_base,
   input  logic [sipl_pkg::SIZE_BITS-1:0]       wr_size,
   input  logic [$clog2(TABLE_DEPTH+1)-1:0]     count,
   // from the previous cell
   input  logic                                 in_valid,
   input  logic [$clog2(TABLE_DEPTH+1)-1:0]     in_pos,
   input  logic [ADDRESS_BITS-1:0]              in_addr,
   input  logic [ADDRESS_BITS-1:0]              in_base,
   input  logic [sipl_pkg::SIZE_BITS-1:0]       in_size,
   // to the next cell
   output logic                                 out_valid,
   output logic [$clog2(TABLE_DEPTH+1)-1:0]     out_pos,
   output logic [ADDRESS_BITS-1:0]              out_addr,
   output logic [ADDRESS_BITS-1:0]              out_base,
   output logic [sipl_pkg::SIZE_BITS-1:0]       out_size
);

   localparam int CNT_BITS  = $clog2(TABLE_DEPTH + 1);
   localparam int SIZE_BITS = sipl_pkg::SIZE_BITS;
   localparam int STEP      = 1 << LEVEL;
   localparam int ROWS      = (TABLE_DEPTH + STEP) >> (LEVEL + 1);
   localparam int ROW_BITS  = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam logic [CNT_BITS-1:0] LOW_MASK = CNT_BITS'((1 << (LEVEL + 1)) - 1);
   localparam logic [CNT_BITS-1:0] LOW_ONES = CNT_BITS'(STEP - 1);
   localparam logic [CNT_BITS:0]   STEP_EXT = (CNT_BITS + 1)'(STEP);

   // entry rows of this cell
   logic [ADDRESS_BITS-1:0] base_mem [ROWS];
   logic [SIZE_BITS-1:0]    size_mem [ROWS];

   logic [ADDRESS_BITS-1:0] rd_base_ff;
   logic [SIZE_BITS-1:0]    rd_size_ff;

   logic                    valid_ff, valid_in;
   logic [CNT_BITS-1:0]     pos_ff;
   logic [ADDRESS_BITS-1:0] addr_ff;
   logic [ADDRESS_BITS-1:0] cand_base_ff;
   logic [SIZE_BITS-1:0]    cand_size_ff;

   logic [ROW_BITS-1:0]     wr_row, rd_row;
   logic                    wr_sel;
   logic [CNT_BITS:0]       reach;
   logic                    take;

   // row selection: the low LEVEL+1 bits pick the cell, the rest the row
   always_comb begin
      wr_sel = wr_en && ((wr_index & LOW_MASK) == LOW_ONES);
      wr_row = ROW_BITS'(wr_index >> (LEVEL + 1));
      rd_row = ROW_BITS'(in_pos >> (LEVEL + 1));
   end

   // entry storage, registered read
   always_ff @(posedge clock) begin
      if (wr_sel) begin
         base_mem[wr_row] <= wr_base;
         size_mem[wr_row] <= wr_size;
      end
      rd_base_ff <= base_mem[rd_row];
      rd_size_ff <= size_mem[rd_row];
   end

   // chain registers
   assign valid_in = in_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff       <= in_pos;
      addr_ff      <= in_addr;
      cand_base_ff <= in_base;
      cand_size_ff <= in_size;
   end

   // search step: advance when the probed entry exists and is not above
   always_comb begin
      reach     = {1'b0, pos_ff} + STEP_EXT;
      take      = (reach <= {1'b0, count}) && (rd_base_ff <= addr_ff);
      out_valid = valid_ff;
      out_addr  = addr_ff;
      out_pos   = take ? CNT_BITS'(reach) : pos_ff;
      out_base  = take ? rd_base_ff : cand_base_ff;
      out_size  = take ? rd_size_ff : cand_size_ff;
   end

   // larger steps leave the position a multiple of twice this step
   a_pos_aligned: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> ((pos_ff & LOW_MASK) == '0))
      else $error("search position not aligned to cell step");

   // the table is never appended while a search walks the chain
   a_no_write_in_search: assert property (@(posedge clock) disable iff (reset)
      !(wr_en && valid_ff))
      else $error("append during search");

endmodule

### src/sipl_check.sv
// ============================================================================
// sipl_check: bounds check at the end of the chain
// Takes the floor entry found by the chain and decides hit or miss from the
// byte offset of the probed address against the entry's size.
// ============================================================================
module sipl_check #(
   parameter int TABLE_DEPTH  = sipl_pkg::DEF_TABLE_DEPTH,
   parameter int ADDRESS_BITS = sipl_pkg::DEF_ADDRESS_BITS
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 in_valid,
   input  logic [$clog2(TABLE_DEPTH+1)-1:0]     in_pos,
   input  logic [ADDRESS_BITS-1:0]              in_addr,
   input  logic [ADDRESS_BITS-1:0]              in_base,
   input  logic [sipl_pkg::SIZE_BITS-1:0]       in_size,
   output logic                                 out_valid,
   output logic [sipl_pkg::STATUS_BITS-1:0]     out_status,
   output logic [ADDRESS_BITS-1:0]              out_base,
   output logic [$clog2(TABLE_DEPTH)-1:0]       out_index
);

   localparam int CNT_BITS   = $clog2(TABLE_DEPTH + 1);
   localparam int INDEX_BITS = $clog2(TABLE_DEPTH);
   localparam int SIZE_BITS  = sipl_pkg::SIZE_BITS;
   localparam int CMP_BITS   = (ADDRESS_BITS > SIZE_BITS) ? ADDRESS_BITS : SIZE_BITS;

   logic                    valid_ff, valid_in;
   logic [CNT_BITS-1:0]     pos_ff;
   logic [ADDRESS_BITS-1:0] addr_ff;
   logic [ADDRESS_BITS-1:0] base_ff;
   logic [SIZE_BITS-1:0]    size_ff;

   logic [ADDRESS_BITS-1:0] offset;
   logic                    hit;
   logic [CNT_BITS-1:0]     floor_index;

   assign valid_in = in_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff  <= in_pos;
      addr_ff <= in_addr;
      base_ff <= in_base;
      size_ff <= in_size;
   end

   // a position of zero means no base lies at or below the address
   always_comb begin
      offset      = addr_ff - base_ff;
      hit         = (pos_ff != '0) &&
                    (CMP_BITS'(offset) < CMP_BITS'(size_ff));
      floor_index = pos_ff - CNT_BITS'(1);
      out_valid   = valid_ff;
      out_status  = hit ? sipl_pkg::ST_HIT : sipl_pkg::ST_MISS;
      out_base    = hit ? base_ff : '0;
      out_index   = hit ? INDEX_BITS'(floor_index) : '0;
   end

   // the floor entry never lies above the probed address
   a_floor_below: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && pos_ff != '0) |-> (base_ff <= addr_ff))
      else $error("floor entry above probed address");

endmodule
